// File: hdl/fsdq_pkg.sv
`timescale 1ns / 1ps

package fsdq_pkg;

  localparam int ID_W    = 8;
  localparam int MASK_W  = 8;
  localparam int RES_W   = 3;
  localparam int NUM_RES = 8;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_SEL = 2'd2,
    OP_QRY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [MASK_W-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic              commit;
    logic              enq;
    logic              rmv;
    logic              head_only;
    logic [RES_W-1:0]  res;
    entry_t            entry;
  } cmd_t;

  typedef struct packed {
    logic   found;
    entry_t taken;
  } link_t;

endpackage

// File: hdl/fifo_with_select_dequeue_core.sv
`timescale 1ns / 1ps

// Ordered queue of (id, need mask) entries with selective removal.
// Input channel s_axis: tuser carries the opcode (enqueue, dequeue head,
// dequeue oldest entry needing a resource, query), tdata the entry id,
// need mask and resource index. Output channel m_axis: one word per input
// word with the removed entry, query flag, empty flag, fill level, status.
// An accepted word is held in the input registers while it executes, and
// its result enters the output register once the receiver is ready; no
// new word is taken before then. The priority match and close-up shift
// ripple along the row of QUEUE_DEPTH cells in the execute step.
// Errors (enqueue when full, dequeue when empty, no matching entry) leave
// the queue unchanged and are reported in the status field.
// Reset empties the queue; entry storage is not cleared.
// When the receiver stalls, the result holds in the output register; one
// more word is taken and waits in the execute step, and s_axis_tready then
// stays low until the output register drains.
module fifo_with_select_dequeue_core #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1),
  localparam int OutW = ((20 + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // entry_id, need_mask, resource_index
  input  logic [1:0]      s_axis_tuser,   // opcode
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // out_id, out_mask, match_found,
                                          // queue_empty, entry_count, status
);
  import fsdq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q;
  op_e               op_q;
  entry_t            in_entry_q;
  logic [RES_W-1:0]  res_q;
  logic [CntW-1:0]   count_q;

  entry_t            out_entry_q;
  logic              out_match_q;
  status_e           out_status_q;
  logic              out_valid_q;

  cmd_t              cmd;
  link_t             link [QUEUE_DEPTH+1];
  entry_t            chain [QUEUE_DEPTH+1];

  logic              fire;
  logic              full;
  logic              empty;
  logic              is_rmv;
  logic              found;
  status_e           status_d;
  logic [CntW-1:0]   count_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;

  assign fire   = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign is_rmv = (op_q == OP_DEQ) || (op_q == OP_SEL);

  assign cmd.commit    = fire;
  assign cmd.enq       = (op_q == OP_ENQ);
  assign cmd.rmv       = is_rmv;
  assign cmd.head_only = (op_q == OP_DEQ);
  assign cmd.res       = res_q;
  assign cmd.entry     = in_entry_q;

  assign link[0]            = '0;
  assign chain[QUEUE_DEPTH] = '0;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    fsdq_cell #(
      .IDX   (k),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .link_i  (link[k]),
      .link_o  (link[k+1]),
      .next_i  (chain[k+1]),
      .entry_o (chain[k])
    );
  end

  assign found = link[QUEUE_DEPTH].found;

  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    unique case (op_q)
      OP_ENQ: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_DEQ, OP_SEL: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOMATCH;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      OP_QRY: begin
        status_d = ST_OK;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q            <= op_e'(s_axis_tuser);
      in_entry_q.id   <= s_axis_tdata[7:0];
      in_entry_q.mask <= s_axis_tdata[15:8];
      res_q           <= s_axis_tdata[18:16];
    end
    if (fire) begin
      out_entry_q  <= (is_rmv && found) ? link[QUEUE_DEPTH].taken : '0;
      out_match_q  <= (op_q == OP_QRY) && found;
      out_status_q <= status_d;
    end
  end

  logic [CntW-1:0] count_out;
  assign count_out = count_q;

  assign m_axis_tdata = OutW'({out_status_q, count_out, (count_out == '0), out_match_q,
                               out_entry_q.mask, out_entry_q.id});

endmodule

// File: hdl/fsdq_cell.sv
`timescale 1ns / 1ps

module fsdq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                clk_i,
  input  fsdq_pkg::cmd_t      cmd_i,
  input  logic [CNT_W-1:0]    count_i,
  input  fsdq_pkg::link_t     link_i,
  output fsdq_pkg::link_t     link_o,
  input  fsdq_pkg::entry_t    next_i,
  output fsdq_pkg::entry_t    entry_o
);
  import fsdq_pkg::*;

  localparam logic IsHead = (IDX == 0);

  entry_t entry_q;
  logic   occ;
  logic   res_ok;
  logic   hit;
  logic   take;

  assign occ    = CNT_W'(IDX) < count_i;
  assign res_ok = {1'b0, cmd_i.res} < (RES_W + 1)'(NUM_RES);
  assign hit    = occ & (cmd_i.head_only ? IsHead : (res_ok & entry_q.mask[cmd_i.res]));
  assign take   = hit & ~link_i.found;

  assign link_o.found      = link_i.found | hit;
  assign link_o.taken.id   = link_i.taken.id   | (take ? entry_q.id   : '0);
  assign link_o.taken.mask = link_i.taken.mask | (take ? entry_q.mask : '0);
  assign entry_o           = entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (cmd_i.rmv && link_o.found) begin
        entry_q <= next_i;
      end else if (cmd_i.enq && (count_i == CNT_W'(IDX))) begin
        entry_q <= cmd_i.entry;
      end
    end
  end

endmodule
